>>> src/rrat_pkg.sv
// Package for the register range allow table: item types, opcodes and sizes.
// Used by every module under src; depends on nothing.
`default_nettype none
package rrat_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] reg_id;
    logic [15:0] span;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_CHECK,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] reg_id;
    logic [32:0] top;
  } cmd_t;

  // One stored range, inclusive ends
  typedef struct packed {
    logic [31:0] base;
    logic [32:0] top;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

endpackage
`default_nettype wire

>>> src/rrat_front.sv
// Front end: accepts input items, decodes the opcode and forms the range top.
// Depends on rrat_pkg.
`default_nettype none
module rrat_front
  import rrat_pkg::*;
(
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  output logic           in_stall,
  input  wire q_status_t q_status,
  output logic           push,
  output cmd_t           push_cmd
);

  always_comb begin
    push_cmd.reg_id = in_item.reg_id;
    // Form the top 33 bits wide so base plus span never wraps
    push_cmd.top    = {1'b0, in_item.reg_id} + {17'd0, in_item.span};
    unique case (in_item.opcode)
      OP_INSERT: push_cmd.kind = CMD_INSERT;
      OP_CHECK:  push_cmd.kind = CMD_CHECK;
      OP_CLEAR:  push_cmd.kind = CMD_CLEAR;
      default:   push_cmd.kind = CMD_NOP;
    endcase
  end

  // Hold the input while the queue is full or the block is in reset
  assign in_stall = q_status.full || !rst_n;
  assign push     = in_valid && !in_stall;

endmodule
`default_nettype wire

>>> src/rrat_queue.sv
// Short queue of classified items between the front and the back end.
// Depends on rrat_pkg.
`default_nettype none
module rrat_queue
  import rrat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output q_status_t  q_status
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head           = q_mem_r[rd_ptr_r];
  assign q_status.empty = (cnt_r == '0);
  assign q_status.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

>>> src/rrat_back.sv
// Back end: holds the range memory, scans it one entry a cycle for checks
// and inserts, and drives the output register. Depends on rrat_pkg.
`default_nettype none
module rrat_back
  import rrat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      check_enable,
  input  wire q_status_t q_status,
  input  wire cmd_t      head,
  output logic           pop,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      out_stall
);

  entry_t            range_mem_r [TABLE_ENTRIES];
  entry_t            rd_data_r;
  entry_t            wr_data;
  logic              rd_en, we;
  logic [IDX_W-1:0]  wr_addr;

  back_state_t       state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              out_free;
  logic              start_scan;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W-1:0]  count_m1;
  logic [32:0]       key_hi;
  logic              entry_match;
  logic              found_now;

  assign out_free = !out_valid_r || !out_stall;
  assign count_m1 = count_r - 1'b1;
  assign last_idx = count_m1[IDX_W-1:0];

  // Check: id inside the entry. Insert: new range wholly inside the entry.
  assign key_hi      = (cur_r.kind == CMD_CHECK) ? {1'b0, cur_r.reg_id} : cur_r.top;
  assign entry_match = (cur_r.reg_id >= rd_data_r.base) && (key_hi <= rd_data_r.top);
  assign found_now   = found_r || (rd_vld_r && entry_match);

  always_comb begin
    unique case (head.kind)
      CMD_INSERT: start_scan = (count_r != '0);
      CMD_CHECK:  start_scan = check_enable && (count_r != '0);
      default:    start_scan = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty && out_free && start_scan) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_idx_r == last_idx) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop           = 1'b0;
    rd_en         = 1'b0;
    we            = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data.base  = cur_r.reg_id;
    wr_data.top   = cur_r.top;
    cur_nxt       = cur_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop          = 1'b1;
          cur_nxt      = head;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          if (!start_scan) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            if (head.kind == CMD_INSERT) begin
              // Empty table: store straight into the first entry
              we           = 1'b1;
              wr_addr      = '0;
              wr_data.base = head.reg_id;
              wr_data.top  = head.top;
              count_nxt    = CNT_W'(1);
            end else if (head.kind == CMD_CLEAR) begin
              count_nxt = '0;
            end
          end
        end
      end
      BK_SCAN: begin
        rd_en        = 1'b1;
        rd_vld_nxt   = 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
        found_nxt    = found_now;
      end
      BK_FINISH: begin
        found_nxt     = found_now;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        if (cur_r.kind == CMD_CHECK) begin
          out_item_nxt.hit = found_now;
        end else if (!found_now) begin
          if (count_r < CNT_W'(TABLE_ENTRIES)) begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            out_item_nxt.dropped = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    scan_idx_r <= scan_idx_nxt;
    found_r    <= found_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      range_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= range_mem_r[scan_idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> src/register_range_allow_table.sv
// Top level of the register range allow table.
// Depends on rrat_pkg, rrat_front, rrat_queue and rrat_back.
//
// Access filter for register numbers. Insert items store inclusive ranges
// [reg_id, reg_id + span] (the top is formed 33 bits wide, so it never wraps),
// check items ask whether reg_id lies in any stored range, and clear items
// empty the table; every item gives exactly one result item. A check misses
// while check_enable is 0 or the table is empty. An insert that lies wholly
// inside one stored range is not stored; otherwise it is appended, or reported
// as dropped when all TABLE_ENTRIES entries are in use. Opcode 3 is ignored
// and returns zeros. The front end decodes items into a two-entry queue, so
// input keeps flowing while the back end works. The back end keeps the ranges
// in a memory with one read port and scans it one entry per cycle: a check
// with checking enabled and an insert into a non-empty table read every
// stored entry; clear, opcode 3, a disabled or empty-table check and the
// first insert skip the scan. Results sit in an output register;
// the back end takes a new item while that register is being drained.
// Write check_enable only while the block is idle; clear keeps its value.
`default_nettype none
module register_range_allow_table
  import rrat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // configuration
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  // input items
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_stall,
  // result items
  output logic          out_valid,
  output out_item_t     out_item,
  input  wire logic     out_stall
);

  logic      check_enable_r, check_enable_nxt;
  q_status_t q_status;
  logic      push, pop;
  cmd_t      push_cmd, head;

  // Hold the enable unless written
  assign check_enable_nxt = cfg_we ? cfg_wdata : check_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enable_r <= 1'b0;
    end else begin
      check_enable_r <= check_enable_nxt;
    end
  end

  // Decode and forward items into the queue
  rrat_front u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rrat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Scan the range memory and drive results
  rrat_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .check_enable (check_enable_r),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .out_stall    (out_stall)
  );

endmodule
`default_nettype wire
